@@ sv/median_filter_3x3_macros.svh @@
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MF3_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("median_filter_3x3: check failed");
// next-cycle implication
`define MF3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("median_filter_3x3: check failed");
`else
`define MF3_ASSERT_IMPL(lbl, ante, cons)
`define MF3_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/mf3_pkg.sv @@
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int WIN_SIZE   = 9;
  localparam int CENTER_TAP = 4;

  localparam int CFG_W_BITS  = 11;
  localparam int CFG_H_BITS  = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam int ROW_W       = 17;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_t;

  // per-item position flags
  typedef struct packed {
    logic have;
    logic border;
    logic eor;
    logic eof;
  } tag_t;

endpackage

@@ sv/mf3_pos.sv @@
// ----------------------------------------------------------------------------
// mf3_pos
// Frame geometry registers and input position tracking; classifies each
// request into result / border / end-of-row / end-of-frame.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_macros.svh"

module mf3_pos #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mf3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_fire,
  output logic [AW-1:0]                   col,
  output mf3_pkg::tag_t                   tag
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int WCMP = (WW > mf3_pkg::CFG_W_BITS) ? WW : mf3_pkg::CFG_W_BITS;
  localparam int RW   = mf3_pkg::ROW_W;

  logic [mf3_pkg::CFG_W_BITS-1:0] width_r;
  logic [mf3_pkg::CFG_H_BITS-1:0] height_r;
  logic [AW-1:0]                  ci_r, ci_nxt;
  logic [RW-1:0]                  ri_r, ri_nxt;

  logic [WCMP-1:0] w_cfg, w_max, w_eff, ci_ext, ci_inc;
  logic [RW-1:0]   h_eff, h_p1;
  logic            col0, row0, col_first, last_row, last_col;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mf3_pkg::WIDTH_RESET;
      height_r <= mf3_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (mf3_pkg::cfg_reg_e_t'(cfg_addr))
        mf3_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_wdata[mf3_pkg::CFG_W_BITS-1:0];
        mf3_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wdata[mf3_pkg::CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported range
  always_comb begin
    w_cfg  = WCMP'(width_r);
    w_max  = WCMP'(MAX_WIDTH);
    if (width_r == '0)
      w_eff = WCMP'(1);
    else if (w_cfg > w_max)
      w_eff = w_max;
    else
      w_eff = w_cfg;
    h_eff  = (height_r == '0) ? RW'(1) : RW'(height_r);
    h_p1   = h_eff + RW'(1);
    ci_ext = WCMP'(ci_r);
    ci_inc = ci_ext + WCMP'(1);
  end

  // classify the current request
  always_comb begin
    col0 = (ci_r == '0);
    if (col0) begin
      // wrap-around: output is the last column of the row two back
      tag.have  = (ri_r >= RW'(2)) && (ri_r <= h_p1);
      row0      = (ri_r == RW'(2));
      last_row  = (ri_r >= h_p1);
      last_col  = 1'b1;
      col_first = 1'b0;
    end else begin
      tag.have  = (ri_r >= RW'(1)) && (ri_r <= h_eff);
      row0      = (ri_r == RW'(1));
      last_row  = (ri_r >= h_eff);
      last_col  = (ci_ext >= w_eff);
      col_first = (ci_r == AW'(1));
    end
    tag.border = row0 || col_first || last_row || last_col;
    tag.eor    = last_col;
    tag.eof    = last_col && last_row;
  end

  // advance the position
  always_comb begin
    if (ri_r >= h_p1) begin
      ci_nxt = '0;
      ri_nxt = '0;
    end else if (ci_inc >= w_eff) begin
      ci_nxt = '0;
      ri_nxt = ri_r + RW'(1);
    end else begin
      ci_nxt = ci_inc[AW-1:0];
      ri_nxt = ri_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r <= '0;
      ri_r <= '0;
    end else if (in_fire) begin
      ci_r <= ci_nxt;
      ri_r <= ri_nxt;
    end
  end

  assign col = ci_r;

  // row count never passes height+1, at most 65536
  `MF3_ASSERT_IMPL(a_row_bound, ri_r[RW-1], ri_r[RW-2:0] == '0)

endmodule

@@ sv/mf3_linebuf.sv @@
// ----------------------------------------------------------------------------
// mf3_linebuf
// Line buffer memory: each entry holds the pixels of the two previous rows
// at one column. One read and one write port, registered read data.
// ----------------------------------------------------------------------------
module mf3_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= wr_data;
    if (rd_en)
      rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/mf3_median.sv @@
// ----------------------------------------------------------------------------
// mf3_median
// Two-stage median-of-nine network with output register: sort each row,
// then median of (max of lows, median of mids, min of highs).
// ----------------------------------------------------------------------------
`include "median_filter_3x3_macros.svh"

module mf3_median (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  mf3_pkg::tag_t  in_tag,
  input  mf3_pkg::win_t  win,
  output logic           out_valid,
  output mf3_pkg::pix_t  out_pixel,
  output logic           out_eor,
  output logic           out_eof
);

  localparam int PW = mf3_pkg::PIX_W;

  typedef logic [2:0][PW-1:0] trio_t;

  function automatic trio_t sort3(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                  input logic [PW-1:0] c);
    logic [PW-1:0] l1, h1, m0;
    trio_t         res;
    l1     = (a < b) ? a : b;
    h1     = (a < b) ? b : a;
    res[2] = (h1 > c) ? h1 : c;
    m0     = (h1 > c) ? c : h1;
    res[0] = (l1 < m0) ? l1 : m0;
    res[1] = (l1 < m0) ? m0 : l1;
    return res;
  endfunction

  function automatic logic [PW-1:0] med3(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                         input logic [PW-1:0] c);
    logic [PW-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  trio_t          srt_r [3];
  mf3_pkg::pix_t  center_r;
  mf3_pkg::tag_t  tag_r;
  logic           a_valid_r;

  mf3_pkg::pix_t  mx_lo, md_mid, mn_hi, med;
  logic           rows_ok;

  logic           out_valid_r, out_eor_r, out_eof_r;
  mf3_pkg::pix_t  out_pixel_r;

  // stage A: sort each window row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        srt_r[r] <= sort3(win[r*3], win[r*3+1], win[r*3+2]);
      end
      center_r <= win[mf3_pkg::CENTER_TAP];
      tag_r    <= in_tag;
    end
  end

  // stage B: combine the sorted rows
  always_comb begin
    mx_lo  = (srt_r[0][0] > srt_r[1][0]) ? srt_r[0][0] : srt_r[1][0];
    mx_lo  = (mx_lo > srt_r[2][0]) ? mx_lo : srt_r[2][0];
    mn_hi  = (srt_r[0][2] < srt_r[1][2]) ? srt_r[0][2] : srt_r[1][2];
    mn_hi  = (mn_hi < srt_r[2][2]) ? mn_hi : srt_r[2][2];
    md_mid = med3(srt_r[0][1], srt_r[1][1], srt_r[2][1]);
    med    = med3(mx_lo, md_mid, mn_hi);
  end

  // output register: border pixels pass the center tap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= tag_r.border ? center_r : med;
      out_eor_r   <= tag_r.eor;
      out_eof_r   <= tag_r.eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_eor   = out_eor_r;
  assign out_eof   = out_eof_r;

  always_comb begin
    rows_ok = 1'b1;
    for (int r = 0; r < 3; r++) begin
      rows_ok = rows_ok && (srt_r[r][0] <= srt_r[r][1]) && (srt_r[r][1] <= srt_r[r][2]);
    end
  end

  // border windows may hold line entries that were never written
  `MF3_ASSERT_IMPL(a_rows_sorted, a_valid_r && !tag_r.border, rows_ok)
  `MF3_ASSERT_IMPL(a_eof_on_eor, out_valid_r && out_eof_r, out_eor_r)

endmodule

@@ sv/median_filter_3x3.sv @@
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grayscale pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per request; in_tuser[0] marks a flush item (pixel
//           taken as 0). After each frame the source sends frame_width+1
//           flush items; the output for a pixel comes frame_width+1 requests
//           after it, and the frame count then restarts by itself.
//   out_* : filtered pixel; out_tlast marks the last pixel of a row,
//           out_tuser[0] the last pixel of the frame. Border pixels (first
//           and last row and column) are passed unchanged.
//   cfg_* : frame_width (index 0) and frame_height (index 1); write only
//           while the stream is idle.
// Throughput: one request per clock when not stalled, set by the pipelined
//   read/modify/write of the line buffer (one read and one write port).
// Pipeline: a request that completes a neighborhood goes through the
//   memory read, window shift, row sort and median register to its result.
// Reset: position counters and the window clear, geometry returns to
//   640x480. The line buffer is not cleared.
// Stall: while out_tready is low with a result pending, the whole pipe
//   holds and in_tready drops.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_macros.svh"

module median_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pixel_in
  input  logic [0:0]                      in_tuser,   // [0] is_padding
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] pixel_out
  output logic                            out_tlast,  // end_of_row
  output logic [0:0]                      out_tuser,  // [0] end_of_frame
  // configuration
  input  logic                            cfg_we,
  input  logic [mf3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = mf3_pkg::PIX_W;
  localparam int DW = 2 * PW;

  logic           adv, in_fire;
  mf3_pkg::pix_t  pix_in;
  logic [AW-1:0]  pos_col;
  mf3_pkg::tag_t  pos_tag;

  logic [DW-1:0]  rd_data, wr_data;
  logic           wr_en;

  logic           s1_valid_r, s1_fwd_r;
  mf3_pkg::pix_t  s1_pix_r, s1_fwd_up_r, s1_fwd_mid_r;
  logic [AW-1:0]  s1_addr_r;
  mf3_pkg::tag_t  s1_tag_r;
  mf3_pkg::pix_t  up_eff, mid_eff;

  mf3_pkg::win_t  win_r;
  logic           s2_valid_r;
  mf3_pkg::tag_t  s2_tag_r;

  logic           med_valid, med_eor, med_eof;
  mf3_pkg::pix_t  med_pixel;

  // pipe advances unless a pending result is stalled
  assign adv       = !med_valid || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && adv;
  assign pix_in    = in_tuser[0] ? '0 : in_tdata;

  mf3_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .col       (pos_col),
    .tag       (pos_tag)
  );

  mf3_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (DW)
  ) u_lb (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (pos_col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data)
  );

  // column read from memory, or forwarded from the write in flight
  assign up_eff  = s1_fwd_r ? s1_fwd_up_r  : rd_data[DW-1:PW];
  assign mid_eff = s1_fwd_r ? s1_fwd_mid_r : rd_data[PW-1:0];

  // write back: middle row moves up, new pixel becomes middle row
  assign wr_en   = adv && s1_valid_r;
  assign wr_data = {mid_eff, s1_pix_r};

  // stage 1: memory read in progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r     <= pix_in;
      s1_addr_r    <= pos_col;
      s1_tag_r     <= pos_tag;
      s1_fwd_r     <= s1_valid_r && (s1_addr_r == pos_col);
      s1_fwd_up_r  <= mid_eff;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  // stage 2: shift the new column into the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_tag_r.have;
      if (s1_valid_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= up_eff;
        win_r[5] <= mid_eff;
        win_r[8] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r <= s1_tag_r;
    end
  end

  mf3_median u_med (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s2_valid_r),
    .in_tag    (s2_tag_r),
    .win       (win_r),
    .out_valid (med_valid),
    .out_pixel (med_pixel),
    .out_eor   (med_eor),
    .out_eof   (med_eof)
  );

  assign out_tvalid   = med_valid;
  assign out_tdata    = med_pixel;
  assign out_tlast    = med_eor;
  assign out_tuser[0] = med_eof;

  `MF3_ASSERT_NEXT(a_win_hold, !adv, $stable(win_r))
  `MF3_ASSERT_IMPL(a_s2_source, $rose(s2_valid_r), $past(s1_valid_r && s1_tag_r.have))

endmodule

@@ sim/median_filter_3x3_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_test
// Self-checking bench for the streaming 3x3 median filter. Pixels are fed as
// whole frames, each followed by its flush requests. A line-buffer and window
// predictor works out every filtered pixel with its row and frame marks. The
// predictor is compared with the result stream under random bursts on the
// input side and random stall patterns on the output side. Geometry sweeps
// small, degenerate, masked and extreme sizes, including changes in the
// middle of a frame.
// ----------------------------------------------------------------------------
module median_filter_3x3_test;

  localparam int MAX_COLS = 1024;

  typedef struct packed {
    logic [7:0] pix;
    logic       eor;
    logic       eof;
  } out_pix_t;

  typedef enum int {PIX_UNIFORM, PIX_BAND, PIX_EXTREME} pix_style_t;
  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_ALTERNATE} ready_mode_t;

  // Line buffers, window and raster position; queue of filtered pixels due
  class pixel_tracker;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  upper_buf [MAX_COLS];
    logic [7:0]  middle_buf [MAX_COLS];
    logic [7:0]  win [3][3];
    int unsigned col;
    int unsigned row;
    out_pix_t    waiting[$];
    int          mismatches;
    int          checked;

    function new();
      width_reg  = mf3_pkg::WIDTH_RESET;
      height_reg = mf3_pkg::HEIGHT_RESET;
      for (int i = 0; i < MAX_COLS; i++) begin
        upper_buf[i]  = 8'd0;
        middle_buf[i] = 8'd0;
      end
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = 8'd0;
      col = 0;
      row = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(mf3_pkg::cfg_reg_e_t idx, logic [mf3_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        mf3_pkg::REG_FRAME_WIDTH:  width_reg = val[mf3_pkg::CFG_W_BITS-1:0];
        mf3_pkg::REG_FRAME_HEIGHT: height_reg = val[mf3_pkg::CFG_H_BITS-1:0];
        default: ;
      endcase
    endfunction

    // zero width counts as one, oversize clamps to the buffer depth
    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_COLS) return MAX_COLS;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function logic [7:0] window_median();
      logic [7:0] v [9];
      logic [7:0] t;
      for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
      for (int i = 0; i < 8; i++)
        for (int j = 0; j < 8 - i; j++)
          if (v[j] > v[j + 1]) begin
            t = v[j];
            v[j] = v[j + 1];
            v[j + 1] = t;
          end
      return v[4];
    endfunction

    // Advance the window by one accepted request and queue any result
    function void take_pixel(logic [7:0] pix_in, logic pad);
      int unsigned w, h, ci, ri, ro, co;
      bit          have;
      bit          last_col, last_row;
      logic [7:0]  pix;
      out_pix_t    res;
      w = eff_width();
      h = eff_height();
      ci = (col >= MAX_COLS) ? 0 : col;
      ri = row;
      ro = 0;
      co = 0;
      pix = pad ? 8'd0 : pix_in;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = upper_buf[ci];
      win[1][2] = middle_buf[ci];
      win[2][2] = pix;
      upper_buf[ci] = middle_buf[ci];
      middle_buf[ci] = pix;

      // output position trails the input by one row and one column
      have = 1'b0;
      if (ci >= 1 && ri >= 1) begin
        ro = ri - 1;
        co = ci - 1;
        have = 1'b1;
      end else if (ci == 0 && ri >= 2) begin
        ro = ri - 2;
        co = w - 1;
        have = 1'b1;
      end
      if (have && ro >= h) have = 1'b0;

      if (ri >= h + 1) begin
        col = 0;
        row = 0;
      end else if (ci + 1 >= w) begin
        col = 0;
        row = ri + 1;
      end else begin
        col = ci + 1;
        row = ri;
      end

      if (have) begin
        last_col = (co >= w - 1);
        last_row = (ro >= h - 1);
        res.pix = (ro == 0 || co == 0 || last_col || last_row) ? win[1][1] : window_median();
        res.eor = last_col;
        res.eof = last_col && last_row;
        waiting.push_back(res);
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] result %0d: %s", $time, checked, msg);
    endtask

    // Compare one accepted result against the oldest pending pixel
    task match_pixel(logic [7:0] pix, logic eor, logic eof);
      out_pix_t want;
      checked++;
      if (waiting.size() == 0) begin
        flag_mismatch($sformatf("unexpected result pixel=%0d", pix));
        return;
      end
      want = waiting.pop_front();
      if (pix !== want.pix)
        flag_mismatch($sformatf("pixel got %0d want %0d", pix, want.pix));
      if (eor !== want.eor)
        flag_mismatch($sformatf("end of row got %b want %b", eor, want.eor));
      if (eof !== want.eof)
        flag_mismatch($sformatf("end of frame got %b want %b", eof, want.eof));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // [7:0] pixel_in
  logic [0:0]                     in_tuser;   // [0] is_padding
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;  // [7:0] pixel_out
  logic                           out_tlast;  // end_of_row
  logic [0:0]                     out_tuser;  // [0] end_of_frame
  logic                           cfg_we;
  logic [mf3_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pixel_tracker trk = new();
  int  items_sent = 0;
  int  burst_left = 0;
  bit  steady = 1'b0;
  bit  stall_request = 1'b0;

  median_filter_3x3 #(.MAX_WIDTH(MAX_COLS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one request, inserting a random gap between bursts
  task automatic push_pixel(input logic [7:0] pix, input logic pad);
    bit ok;
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= pad;
    do begin
      @(negedge clk);
      ok = (in_tready === 1'b1);
      @(posedge clk);
    end while (!ok);
    trk.take_pixel(pix, pad);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_pixel(pix_style_t style, logic [7:0] base);
    case (style)
      PIX_BAND:    return base ^ 8'($urandom_range(0, 7));
      PIX_EXTREME: return ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                          ($urandom_range(0, 1) ? 8'd255 : 8'd0);
      default:     return 8'($urandom);
    endcase
  endfunction

  // Feed pixels from the current position until the frame wraps (count == 0)
  // or until count requests have gone; flush rows are mostly padding
  task automatic run_frame(input pix_style_t style, input int count);
    logic [7:0] base;
    logic       pad;
    int         n;
    base = 8'($urandom);
    n = 0;
    while (n == 0 || ((count == 0) ? (trk.row != 0 || trk.col != 0) : (n < count))) begin
      if (trk.row >= trk.eff_height())
        pad = ($urandom_range(0, 19) != 0);
      else
        pad = ($urandom_range(0, 29) == 0);
      push_pixel(pick_pixel(style, base), pad);
      n++;
    end
  endtask

  // Stop sending, wait for every pending pixel, then let the pipe settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (trk.waiting.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [mf3_pkg::CFG_DATA_W-1:0] w_val,
                              input logic [mf3_pkg::CFG_DATA_W-1:0] h_val);
    cfg_we    <= 1'b1;
    cfg_addr  <= mf3_pkg::REG_FRAME_WIDTH;
    cfg_wdata <= w_val;
    @(posedge clk);
    trk.set_reg(mf3_pkg::REG_FRAME_WIDTH, w_val);
    cfg_addr  <= mf3_pkg::REG_FRAME_HEIGHT;
    cfg_wdata <= h_val;
    @(posedge clk);
    trk.set_reg(mf3_pkg::REG_FRAME_HEIGHT, h_val);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int w, input int h, input int frames);
    wait_idle();
    set_geometry(mf3_pkg::CFG_DATA_W'(w), mf3_pkg::CFG_DATA_W'(h));
    repeat (frames) run_frame(pix_style_t'($urandom_range(0, 2)), 0);
  endtask

  // Result side: sample before the edge, check after it, pick next ready
  initial begin
    ready_mode_t mode;
    int          span;
    int          hold_left;
    bit          fire;
    bit          rdy;
    bit          toggle;
    logic [7:0]  pix;
    logic        eor;
    logic        eof;
    out_tready <= 1'b0;
    mode = RDY_ALWAYS;
    span = 0;
    hold_left = 0;
    toggle = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      @(negedge clk);
      fire = (out_tvalid === 1'b1) && (out_tready === 1'b1);
      pix = out_tdata;
      eor = out_tlast;
      eof = out_tuser[0];
      @(posedge clk);
      if (fire) trk.match_pixel(pix, eor, eof);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = 150;
      end
      if (span == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        span = $urandom_range(16, 160);
      end
      span--;
      toggle = ~toggle;
      case (mode)
        RDY_HALF:      rdy = 1'($urandom_range(0, 1));
        RDY_SPARSE:    rdy = ($urandom_range(0, 3) == 0);
        RDY_ALTERNATE: rdy = toggle;
        default:       rdy = 1'b1;
      endcase
      // long hold-off so the pipe fills and back-pressures the input
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // Stimulus
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= mf3_pkg::REG_FRAME_WIDTH;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: extremes, padding inside the frame, a real pixel in the flush
    set_geometry(16'd3, 16'd3);
    push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);   push_pixel(8'd128, 1'b0);
    push_pixel(8'd7, 1'b0);   push_pixel(8'd255, 1'b0); push_pixel(8'd0, 1'b0);
    push_pixel(8'd1, 1'b0);   push_pixel(8'd2, 1'b0);   push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b1);  push_pixel(8'hA5, 1'b0);  push_pixel(8'h3C, 1'b1);
    push_pixel(8'hFF, 1'b1);

    // zero width and zero height both count as one
    wait_idle();
    set_geometry(16'd0, 16'd0);
    push_pixel(8'h5A, 1'b0); push_pixel(8'h00, 1'b1); push_pixel(8'h00, 1'b1);

    // 2x2 frame is border only
    wait_idle();
    set_geometry(16'd2, 16'd2);
    push_pixel(8'h81, 1'b0); push_pixel(8'h7E, 1'b0);
    push_pixel(8'hC3, 1'b0); push_pixel(8'h18, 1'b0);
    push_pixel(8'h00, 1'b1); push_pixel(8'h00, 1'b1); push_pixel(8'h00, 1'b1);

    // long receiver hold-off while the sender keeps going
    wait_idle();
    set_geometry(16'd10, 16'd8);
    stall_request = 1'b1;
    steady = 1'b1;
    repeat (2) run_frame(PIX_UNIFORM, 0);
    steady = 1'b0;

    // geometry shrunk mid-frame: column past the new width, then early restart
    run_phase(6, 5, 1);
    run_frame(PIX_BAND, 16);
    wait_idle();
    set_geometry(16'd4, 16'd2);
    run_frame(PIX_BAND, 0);
    run_frame(PIX_UNIFORM, 0);
    run_phase(6, 5, 1);
    run_frame(PIX_UNIFORM, 20);
    wait_idle();
    set_geometry(16'd6, 16'd1);
    run_frame(PIX_EXTREME, 0);

    // random small geometries, mostly well-formed frames
    while (items_sent < 780) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        run_phase($urandom_range(3, 16), $urandom_range(3, 10), 1);
      else
        run_phase($urandom_range(1, 12), $urandom_range(1, 9), $urandom_range(1, 2));
    end

    // upper bits of the width write are dropped
    steady = 1'b0;
    wait_idle();
    set_geometry(16'hF803, 16'd5);
    run_frame(PIX_UNIFORM, 0);

    // oversize width and tallest height; stop part way along the first row
    steady = 1'b1;
    wait_idle();
    set_geometry(16'd2047, 16'd65535);
    run_frame(PIX_UNIFORM, 40);
    steady = 1'b0;
    run_phase(5, 4, 1);
    run_phase(5, 4, 2);

    wait_idle();
    if (trk.mismatches == 0 && trk.waiting.size() == 0)
      $display("median_filter_3x3 test passed");
    else
      $display("median_filter_3x3 test failed");
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("median_filter_3x3 test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/mf3_pkg.sv
sv/mf3_pos.sv
sv/mf3_linebuf.sv
sv/mf3_median.sv
sv/median_filter_3x3.sv
sim/median_filter_3x3_test.sv
